[hdl/hmm_viterbi_log_domain_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the log-domain Viterbi unit
// Concurrent property wrappers clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HMM_VITERBI_LOG_DOMAIN_UNIT_DEFINES_SVH
`define HMM_VITERBI_LOG_DOMAIN_UNIT_DEFINES_SVH

// same-cycle implication
`define VITLOG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vitlog: property violated");

// next-cycle implication
`define VITLOG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vitlog: property violated");

`endif

[hdl/vitlog_pkg.sv]
// ----------------------------------------------------------------------------
// vitlog_pkg
// Shared types, codes and arithmetic helpers for the log-domain Viterbi unit.
// ----------------------------------------------------------------------------
`default_nettype none

package vitlog_pkg;

    localparam int MAX_STATES  = 16;
    localparam int MAX_SYMBOLS = 16;
    localparam int MAX_LEN     = 1024;

    localparam int ST_W    = $clog2(MAX_STATES);
    localparam int SYM_W   = $clog2(MAX_SYMBOLS);
    localparam int LEN_W   = $clog2(MAX_LEN);
    localparam int CNT_W   = 5;
    localparam int BP_AW   = LEN_W + ST_W;
    localparam int EMIT_AW = ST_W + SYM_W;

    localparam logic [2:0] FUNC_LOAD_TRANS = 3'd0;
    localparam logic [2:0] FUNC_LOAD_EMIT  = 3'd1;
    localparam logic [2:0] FUNC_LOAD_INIT  = 3'd2;
    localparam logic [2:0] FUNC_OBSERVE    = 3'd3;
    localparam logic [2:0] FUNC_TRACE      = 3'd4;

    localparam logic REG_NUM_STATES  = 1'b0;
    localparam logic REG_NUM_SYMBOLS = 1'b1;

    localparam logic KIND_TERM  = 1'b0;
    localparam logic KIND_TRACE = 1'b1;

    localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;

    typedef logic signed [31:0] score_t;

    typedef struct packed {
        logic [2:0]         func;
        logic [3:0]         row_index;
        logic [3:0]         col_index;
        logic signed [31:0] log_score;
        logic [3:0]         symbol;
        logic               first_obs;
        logic               last_obs;
    } item_t;

    typedef struct packed {
        logic               kind;
        logic [3:0]         path_state;
        logic [9:0]         time_index;
        logic signed [31:0] best_score;
        logic               path_end;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACS,
        ST_COPY,
        ST_SCAN,
        ST_TB_RD,
        ST_TB_OUT
    } state_t;

    typedef struct packed {
        logic               we_trans;
        logic               we_emit;
        logic               we_init;
        logic [ST_W-1:0]    row;
        logic [ST_W-1:0]    col;
        logic signed [31:0] data;
    } tbl_wr_t;

    typedef struct packed {
        logic               valid;
        logic [ST_W-1:0]    j;
        logic signed [31:0] score;
        logic [ST_W-1:0]    arg;
    } acs_res_t;

    function automatic score_t sat_add(input score_t a, input score_t b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31])
            return s[32] ? Q_MIN : Q_MAX;
        return s[31:0];
    endfunction

    // 0 acts as 1, anything above hi acts as hi
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                     input logic [CNT_W-1:0] hi);
        if (v == '0)
            return CNT_W'(1);
        if (v > hi)
            return hi;
        return v;
    endfunction

endpackage

`default_nettype wire

[hdl/vitlog_tables.sv]
// ----------------------------------------------------------------------------
// vitlog_tables
// Transition, emission and initial score memories with registered reads.
// Transition memory is split into one lane per source state.
// ----------------------------------------------------------------------------
`default_nettype none

module vitlog_tables (
    input  wire logic                                     clk,
    input  wire vitlog_pkg::tbl_wr_t                      wr,
    input  wire logic [vitlog_pkg::ST_W-1:0]              rd_j,
    input  wire logic [vitlog_pkg::SYM_W-1:0]             rd_sym,
    output logic [vitlog_pkg::MAX_STATES-1:0][31:0]       trans_row,
    output vitlog_pkg::score_t                            emit_q,
    output vitlog_pkg::score_t                            init_q
);

    logic [31:0] trans_mem [vitlog_pkg::MAX_STATES][vitlog_pkg::MAX_STATES];
    logic [31:0] emit_mem  [vitlog_pkg::MAX_STATES * vitlog_pkg::MAX_SYMBOLS];
    logic [31:0] init_mem  [vitlog_pkg::MAX_STATES];

    always_ff @(posedge clk)
    begin
        if (wr.we_trans)
            trans_mem[wr.row][wr.col] <= wr.data;
        if (wr.we_emit)
            emit_mem[{wr.row, wr.col}] <= wr.data;
        if (wr.we_init)
            init_mem[wr.row] <= wr.data;
    end

    // one column of the transition matrix per read: all sources into rd_j
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < vitlog_pkg::MAX_STATES; i++)
        begin
            trans_row[i] <= trans_mem[i][rd_j];
        end
        emit_q <= emit_mem[{rd_j, rd_sym}];
        init_q <= init_mem[rd_j];
    end

endmodule

`default_nettype wire

[hdl/vitlog_acs.sv]
// ----------------------------------------------------------------------------
// vitlog_acs
// Add-compare-select pipeline: one destination state enters per cycle.
// Adds, two compare-tree stages, then the emission add.
// ----------------------------------------------------------------------------
`default_nettype none

module vitlog_acs (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     issue,
    input  wire logic [vitlog_pkg::ST_W-1:0]              issue_j,
    input  wire logic                                     first,
    input  wire logic [vitlog_pkg::MAX_STATES-1:0]        lane_en,
    input  wire logic [vitlog_pkg::MAX_STATES-1:0][31:0]  score_prev,
    input  wire logic [vitlog_pkg::MAX_STATES-1:0][31:0]  trans_row,
    input  wire vitlog_pkg::score_t                       emit_q,
    input  wire vitlog_pkg::score_t                       init_q,
    output vitlog_pkg::acs_res_t                          res
);

    localparam int NS   = vitlog_pkg::MAX_STATES;
    localparam int STW  = vitlog_pkg::ST_W;
    localparam int L1N  = NS / 2;
    localparam int L2N  = NS / 4;
    localparam int L3N  = NS / 8;

    logic               v0_reg, v1_reg, v2_reg, v3_reg;
    logic [STW-1:0]     j0_reg, j1_reg, j2_reg, j3_reg;

    logic signed [31:0] cand_reg [NS];
    logic               cv_reg   [NS];
    vitlog_pkg::score_t emit1_reg, emit2_reg, emit3_reg;
    vitlog_pkg::score_t init1_reg, init2_reg, init3_reg;

    logic signed [31:0] l1_val [L1N];
    logic [STW-1:0]     l1_idx [L1N];
    logic               l1_v   [L1N];
    logic signed [31:0] l2_val [L2N];
    logic [STW-1:0]     l2_idx [L2N];
    logic               l2_v   [L2N];
    logic signed [31:0] l2_val_reg [L2N];
    logic [STW-1:0]     l2_idx_reg [L2N];
    logic               l2_v_reg   [L2N];
    logic signed [31:0] l3_val [L3N];
    logic [STW-1:0]     l3_idx [L3N];
    logic               l3_v   [L3N];
    logic signed [31:0] best;
    logic [STW-1:0]     best_idx;

    logic               res_valid_reg;
    logic [STW-1:0]     res_j_reg;
    vitlog_pkg::score_t res_score_reg;
    logic [STW-1:0]     res_arg_reg;

    // stage 1: source score plus transition, per lane
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NS; i++)
        begin
            cand_reg[i] <= vitlog_pkg::sat_add(score_prev[i], trans_row[i]);
            cv_reg[i]   <= lane_en[i];
        end
        emit1_reg <= emit_q;
        init1_reg <= init_q;
    end

    // lower index keeps ties: the higher one wins only when strictly greater
    always_comb
    begin
        for (int k = 0; k < L1N; k++)
        begin
            if (cv_reg[2*k+1] && (!cv_reg[2*k] || (cand_reg[2*k+1] > cand_reg[2*k])))
            begin
                l1_val[k] = cand_reg[2*k+1];
                l1_idx[k] = STW'(2*k+1);
                l1_v[k]   = 1'b1;
            end
            else
            begin
                l1_val[k] = cand_reg[2*k];
                l1_idx[k] = STW'(2*k);
                l1_v[k]   = cv_reg[2*k];
            end
        end
        for (int k = 0; k < L2N; k++)
        begin
            if (l1_v[2*k+1] && (!l1_v[2*k] || (l1_val[2*k+1] > l1_val[2*k])))
            begin
                l2_val[k] = l1_val[2*k+1];
                l2_idx[k] = l1_idx[2*k+1];
                l2_v[k]   = 1'b1;
            end
            else
            begin
                l2_val[k] = l1_val[2*k];
                l2_idx[k] = l1_idx[2*k];
                l2_v[k]   = l1_v[2*k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < L2N; k++)
        begin
            l2_val_reg[k] <= l2_val[k];
            l2_idx_reg[k] <= l2_idx[k];
            l2_v_reg[k]   <= l2_v[k];
        end
        emit2_reg <= emit1_reg;
        init2_reg <= init1_reg;
    end

    always_comb
    begin
        for (int k = 0; k < L3N; k++)
        begin
            if (l2_v_reg[2*k+1] && (!l2_v_reg[2*k] || (l2_val_reg[2*k+1] > l2_val_reg[2*k])))
            begin
                l3_val[k] = l2_val_reg[2*k+1];
                l3_idx[k] = l2_idx_reg[2*k+1];
                l3_v[k]   = 1'b1;
            end
            else
            begin
                l3_val[k] = l2_val_reg[2*k];
                l3_idx[k] = l2_idx_reg[2*k];
                l3_v[k]   = l2_v_reg[2*k];
            end
        end
        if (l3_v[1] && (!l3_v[0] || (l3_val[1] > l3_val[0])))
        begin
            best     = l3_val[1];
            best_idx = l3_idx[1];
        end
        else
        begin
            best     = l3_val[0];
            best_idx = l3_idx[0];
        end
    end

    logic signed [31:0] best3_reg;
    logic [STW-1:0]     arg3_reg;

    always_ff @(posedge clk)
    begin
        best3_reg     <= best;
        arg3_reg      <= best_idx;
        emit3_reg     <= emit2_reg;
        init3_reg     <= init2_reg;
        res_j_reg     <= j3_reg;
        res_score_reg <= vitlog_pkg::sat_add(first ? init3_reg : best3_reg, emit3_reg);
        res_arg_reg   <= first ? '0 : arg3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
            j0_reg        <= '0;
            j1_reg        <= '0;
            j2_reg        <= '0;
            j3_reg        <= '0;
        end
        else
        begin
            v0_reg        <= issue;
            v1_reg        <= v0_reg;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            res_valid_reg <= v3_reg;
            j0_reg        <= issue_j;
            j1_reg        <= j0_reg;
            j2_reg        <= j1_reg;
            j3_reg        <= j2_reg;
        end
    end

    assign res = {res_valid_reg, res_j_reg, res_score_reg, res_arg_reg};

endmodule

`default_nettype wire

[hdl/vitlog_bptr.sv]
// ----------------------------------------------------------------------------
// vitlog_bptr
// Back-pointer memory: one source index per (time step, state).
// ----------------------------------------------------------------------------
`default_nettype none

module vitlog_bptr (
    input  wire logic                              clk,
    input  wire logic                              we,
    input  wire logic [vitlog_pkg::BP_AW-1:0]      waddr,
    input  wire logic [vitlog_pkg::ST_W-1:0]       wdata,
    input  wire logic [vitlog_pkg::BP_AW-1:0]      raddr,
    output logic [vitlog_pkg::ST_W-1:0]            rdata
);

    logic [vitlog_pkg::ST_W-1:0] mem [2**vitlog_pkg::BP_AW];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hdl/hmm_viterbi_log_domain_unit.sv]
// ----------------------------------------------------------------------------
// hmm_viterbi_log_domain_unit
// Log-domain Viterbi decoder with Q16.16 saturating scores.
// ----------------------------------------------------------------------------
// Usage:
//   An item beat is taken when start is high and busy is low. Load items
//   (transition, emission, initial) are written at that edge and leave busy
//   low. An observation, unless the sequence is full, runs one destination
//   state per cycle through the five-stage add-compare-select pipeline,
//   then copies the new scores. A last observation adds a scan over the
//   states for the best final state, then strobes the termination result.
//   A traceback step reads the back-pointer memory, then strobes the next
//   path state. Each result sits on result for one cycle with result_valid
//   high; the receiver cannot stall it.
//   Register writes through the APB port (num_states at 0, num_symbols at 4)
//   must be made while the unit is idle; the unit itself does not enforce
//   this. Reset clears the counters, the trace position and the registers
//   to 16; the score tables hold garbage until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module hmm_viterbi_log_domain_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire vitlog_pkg::item_t   item,
    output logic                     result_valid,
    output vitlog_pkg::result_t      result,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int NS    = vitlog_pkg::MAX_STATES;
    localparam int STW   = vitlog_pkg::ST_W;
    localparam int CW    = vitlog_pkg::CNT_W;
    localparam int LW    = vitlog_pkg::LEN_W;

    vitlog_pkg::state_t   state_reg, state_next;
    logic [CW-1:0]        num_states_reg, num_symbols_reg;
    logic [LW-1:0]        step_reg;
    logic [STW-1:0]       trace_state_reg;
    logic [LW-1:0]        trace_time_reg;
    logic [STW-1:0]       iss_reg;
    logic                 iss_active_reg;
    logic [STW-1:0]       scan_idx_reg;
    logic                 result_valid_reg;
    vitlog_pkg::result_t  result_reg;

    logic [NS-1:0][31:0]  score_prev_reg;
    logic [NS-1:0][31:0]  score_next_reg;
    logic [STW-1:0]       sym_reg;
    logic                 first_reg, last_reg;
    vitlog_pkg::score_t   best_reg;
    logic [STW-1:0]       arg_reg;

    logic [CW-1:0]        ns_eff, nsym_eff;
    logic [STW-1:0]       ns_m1;
    logic [STW-1:0]       sym_clamped;
    logic [NS-1:0]        lane_en;
    logic                 accept, cfg_we;
    logic                 obs_run, obs_skip;
    logic                 acs_done;
    vitlog_pkg::tbl_wr_t  tbl_wr;
    logic [NS-1:0][31:0]  trans_row;
    vitlog_pkg::score_t   emit_q, init_q;
    vitlog_pkg::acs_res_t acs_res;
    logic [STW-1:0]       bp_q;
    vitlog_pkg::score_t   scan_val, best_sel;
    logic [STW-1:0]       arg_sel;
    logic                 scan_last;
    logic [LW-1:0]        tb_time;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign prdata = (paddr[2] == vitlog_pkg::REG_NUM_SYMBOLS) ?
                    {(32-CW)'(0), num_symbols_reg} : {(32-CW)'(0), num_states_reg};

    assign ns_eff   = vitlog_pkg::clamp_count(num_states_reg, CW'(NS));
    assign nsym_eff = vitlog_pkg::clamp_count(num_symbols_reg, CW'(vitlog_pkg::MAX_SYMBOLS));
    assign ns_m1    = STW'(ns_eff - CW'(1));
    assign sym_clamped = ({1'b0, item.symbol} >= nsym_eff) ?
                         STW'(nsym_eff - CW'(1)) : item.symbol;

    always_comb
    begin
        for (int i = 0; i < NS; i++)
        begin
            lane_en[i] = (STW'(i) <= ns_m1);
        end
    end

    assign busy   = (state_reg != vitlog_pkg::ST_IDLE);
    assign accept = start && !busy;

    // ---------------- tables and datapath ----------------
    assign tbl_wr.we_trans = accept && (item.func == vitlog_pkg::FUNC_LOAD_TRANS);
    assign tbl_wr.we_emit  = accept && (item.func == vitlog_pkg::FUNC_LOAD_EMIT);
    assign tbl_wr.we_init  = accept && (item.func == vitlog_pkg::FUNC_LOAD_INIT);
    assign tbl_wr.row      = item.row_index;
    assign tbl_wr.col      = item.col_index;
    assign tbl_wr.data     = item.log_score;

    vitlog_tables u_tables (
        .clk       (clk),
        .wr        (tbl_wr),
        .rd_j      (iss_reg),
        .rd_sym    (sym_reg),
        .trans_row (trans_row),
        .emit_q    (emit_q),
        .init_q    (init_q)
    );

    vitlog_acs u_acs (
        .clk        (clk),
        .rst_n      (rst_n),
        .issue      (iss_active_reg),
        .issue_j    (iss_reg),
        .first      (first_reg),
        .lane_en    (lane_en),
        .score_prev (score_prev_reg),
        .trans_row  (trans_row),
        .emit_q     (emit_q),
        .init_q     (init_q),
        .res        (acs_res)
    );

    vitlog_bptr u_bptr (
        .clk   (clk),
        .we    (acs_res.valid && !first_reg),
        .waddr ({LW'(step_reg + LW'(1)), acs_res.j}),
        .wdata (acs_res.arg),
        .raddr ({trace_time_reg, trace_state_reg}),
        .rdata (bp_q)
    );

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vitlog_pkg::ST_IDLE:
            begin
                if (obs_run)
                    state_next = vitlog_pkg::ST_ACS;
                else if (obs_skip && item.last_obs)
                    state_next = vitlog_pkg::ST_SCAN;
                else if (accept && (item.func == vitlog_pkg::FUNC_TRACE)
                         && (trace_time_reg != '0))
                    state_next = vitlog_pkg::ST_TB_RD;
            end
            vitlog_pkg::ST_ACS:
            begin
                if (acs_done)
                    state_next = vitlog_pkg::ST_COPY;
            end
            vitlog_pkg::ST_COPY:
            begin
                state_next = last_reg ? vitlog_pkg::ST_SCAN : vitlog_pkg::ST_IDLE;
            end
            vitlog_pkg::ST_SCAN:
            begin
                if (scan_last)
                    state_next = vitlog_pkg::ST_IDLE;
            end
            vitlog_pkg::ST_TB_RD:
            begin
                state_next = vitlog_pkg::ST_TB_OUT;
            end
            vitlog_pkg::ST_TB_OUT:
            begin
                state_next = vitlog_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = vitlog_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- control decode ----------------
    always_comb
    begin
        obs_run  = 1'b0;
        obs_skip = 1'b0;
        if (accept && (item.func == vitlog_pkg::FUNC_OBSERVE))
        begin
            // sequence full: scores and back-pointers stay as they are
            if (item.first_obs || (step_reg != LW'(vitlog_pkg::MAX_LEN - 1)))
                obs_run = 1'b1;
            else
                obs_skip = 1'b1;
        end
        acs_done  = (state_reg == vitlog_pkg::ST_ACS) && acs_res.valid
                    && (acs_res.j == ns_m1);
        scan_last = (state_reg == vitlog_pkg::ST_SCAN) && (scan_idx_reg == ns_m1);
        scan_val  = score_prev_reg[scan_idx_reg];
        if ((scan_idx_reg == '0) || (scan_val > best_reg))
        begin
            best_sel = scan_val;
            arg_sel  = scan_idx_reg;
        end
        else
        begin
            best_sel = best_reg;
            arg_sel  = arg_reg;
        end
        tb_time = trace_time_reg - LW'(1);
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= vitlog_pkg::ST_IDLE;
            num_states_reg   <= CW'(NS);
            num_symbols_reg  <= CW'(vitlog_pkg::MAX_SYMBOLS);
            step_reg         <= '0;
            trace_state_reg  <= '0;
            trace_time_reg   <= '0;
            iss_reg          <= '0;
            iss_active_reg   <= 1'b0;
            scan_idx_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                if (paddr[2] == vitlog_pkg::REG_NUM_SYMBOLS)
                    num_symbols_reg <= pwdata[CW-1:0];
                else
                    num_states_reg <= pwdata[CW-1:0];
            end

            if (obs_run)
            begin
                iss_reg        <= '0;
                iss_active_reg <= 1'b1;
            end
            else if (iss_active_reg)
            begin
                if (iss_reg == ns_m1)
                    iss_active_reg <= 1'b0;
                else
                    iss_reg <= iss_reg + STW'(1);
            end

            if (state_reg == vitlog_pkg::ST_COPY)
                step_reg <= first_reg ? '0 : LW'(step_reg + LW'(1));

            if (state_reg == vitlog_pkg::ST_SCAN)
                scan_idx_reg <= scan_idx_reg + STW'(1);
            else
                scan_idx_reg <= '0;

            if (scan_last)
            begin
                trace_state_reg  <= arg_sel;
                trace_time_reg   <= step_reg;
                result_valid_reg <= 1'b1;
            end

            if (state_reg == vitlog_pkg::ST_TB_OUT)
            begin
                trace_state_reg  <= bp_q;
                trace_time_reg   <= tb_time;
                result_valid_reg <= 1'b1;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sym_reg   <= sym_clamped;
            first_reg <= item.first_obs;
            last_reg  <= item.last_obs;
        end

        if (acs_res.valid)
            score_next_reg[acs_res.j] <= acs_res.score;

        if (state_reg == vitlog_pkg::ST_COPY)
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (lane_en[i])
                    score_prev_reg[i] <= score_next_reg[i];
            end
        end

        if (state_reg == vitlog_pkg::ST_SCAN)
        begin
            best_reg <= best_sel;
            arg_reg  <= arg_sel;
        end

        if (scan_last)
        begin
            result_reg.kind       <= vitlog_pkg::KIND_TERM;
            result_reg.path_state <= arg_sel;
            result_reg.time_index <= step_reg;
            result_reg.best_score <= best_sel;
            result_reg.path_end   <= (step_reg == '0);
        end
        else if (state_reg == vitlog_pkg::ST_TB_OUT)
        begin
            result_reg.kind       <= vitlog_pkg::KIND_TRACE;
            result_reg.path_state <= bp_q;
            result_reg.time_index <= tb_time;
            result_reg.best_score <= '0;
            result_reg.path_end   <= (tb_time == '0);
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

[hdl/vitlog_checker.sv]
// ----------------------------------------------------------------------------
// vitlog_checker
// Port-level properties of the Viterbi unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hmm_viterbi_log_domain_unit_defines.svh"

module vitlog_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire vitlog_pkg::item_t   item,
    input wire logic                result_valid,
    input wire vitlog_pkg::result_t result,
    input wire logic                psel,
    input wire logic                penable,
    input wire logic                pwrite,
    input wire logic [2:0]          paddr,
    input wire logic [31:0]         pwdata,
    input wire logic [31:0]         prdata,
    input wire logic                pready
);

    // no two result beats in a row: every result ends its item
    `VITLOG_ASSERT_NEXT(a_single_strobe, result_valid, !result_valid)

    `VITLOG_ASSERT_IMPL(a_end_flag, result_valid, result.path_end == (result.time_index == '0))

    `VITLOG_ASSERT_IMPL(a_trace_zero_score, result_valid && (result.kind == vitlog_pkg::KIND_TRACE), result.best_score == '0)

    // emission-table loads complete in the accepting cycle
    `VITLOG_ASSERT_NEXT(a_load_idle, start && !busy && (item.func == vitlog_pkg::FUNC_LOAD_EMIT), !busy)

endmodule

bind hmm_viterbi_log_domain_unit vitlog_checker u_vitlog_checker (.*);

`default_nettype wire
